/* src/clsr_pkg.sv */
// ============================================================================
// clsr_pkg: shared types and constants for the combined LCG shuffle generator
// Generator constants, sequencer states, unit request structs, slot decode.
// ============================================================================
package clsr_pkg;

    localparam int unsigned WordW     = 31;
    localparam int unsigned TableDepth = 32;
    localparam int unsigned AddrW     = $clog2(TableDepth);
    localparam int unsigned CntW      = 6;
    localparam int unsigned MulW      = 16;
    localparam int unsigned ProdW     = WordW + MulW;

    localparam logic [WordW-1:0] MulOne   = 31'd40014;
    localparam logic [WordW-1:0] ModOne   = 31'd2147483563;
    localparam logic [WordW-1:0] MulTwo   = 31'd40692;
    localparam logic [WordW-1:0] ModTwo   = 31'd2147483399;
    // 2^31 mod m, used to fold the high part of the product back in
    localparam logic [7:0]       FoldOne  = 8'd85;
    localparam logic [7:0]       FoldTwo  = 8'd249;
    localparam logic [WordW-1:0] WrapAdd  = 31'd2147483562;
    localparam logic [26:0]      SlotDiv  = 27'd67108862;
    localparam logic [WordW-1:0] GenOneRst = 31'd1;
    localparam logic [WordW-1:0] GenTwoRst = 31'd123456789;
    localparam logic [CntW-1:0]  WarmSteps = 6'd8;
    localparam logic [CntW-1:0]  LastStep  = 6'd39;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_ISSUE,
        ST_SEED_WAIT,
        ST_DRAW_G1,
        ST_DRAW_G2,
        ST_DRAW_WAIT,
        ST_DRAW_FINISH
    } t_state;

    typedef enum logic {
        GEN_ONE,
        GEN_TWO
    } t_gen;

    typedef struct packed {
        logic             start;
        t_gen             sel;
        logic [WordW-1:0] operand;
    } t_mm_req;

    typedef struct packed {
        logic             rd_en;
        logic [AddrW-1:0] rd_addr;
        logic             wr_en;
        logic [AddrW-1:0] wr_addr;
        logic [WordW-1:0] wr_data;
    } t_tbl_req;

    // Slot = v / 67108862, clamped to the last entry. The divisor is
    // 2^26 - 2, so v>>26 is at most one short of the quotient.
    function automatic logic [AddrW-1:0] slot_of(input logic [WordW-1:0] v);
        logic [AddrW-1:0] q0;
        logic [26:0]      rem;
        q0  = v[30:26];
        rem = {1'b0, v[25:0]} + {21'd0, q0, 1'b0};
        if (q0 == AddrW'(TableDepth - 1)) begin
            slot_of = q0;
        end else if (rem >= SlotDiv) begin
            slot_of = q0 + AddrW'(1);
        end else begin
            slot_of = q0;
        end
    endfunction

endpackage

/* src/combined_lcg_shuffle_rng.sv */
// ============================================================================
// combined_lcg_shuffle_rng: combined two-generator LCG with shuffle table
// Each accepted word is a draw request; each draw returns one output word.
// ============================================================================
// Input channel: i_valid / o_stall with i_reseed and i_seed_value. A word is
// taken when i_valid is high and o_stall is low; o_stall is high while a
// draw is in progress.
// Output channel: o_valid / i_stall with o_random_value, held in an output
// register, so a new request is taken while the previous result waits.
// A plain draw issues both generator steps back to back through one two-stage
// modular multiplier, reads the shuffle table in its first step and refills
// it in its last step, where the output register is loaded too.
// A reseed adds 40 serial generator steps, each of which waits for the
// multiplier result before the next one is issued.
// Requests are not overlapped: a new one is taken only after the previous
// draw, with any reseed, is back in idle.
// Reset: generator one = 1, generator two = 123456789, last output = 0, and
// every table entry reads as zero until written.
// If the receiver stalls with a result still held, the next draw finishes
// its arithmetic and waits in its last step until the register frees.
// ============================================================================
module combined_lcg_shuffle_rng (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_reseed,
    input  logic [clsr_pkg::WordW-1:0] i_seed_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [clsr_pkg::WordW-1:0] o_random_value
);
    import clsr_pkg::*;

    t_state           r_state, n_state;
    logic [WordW-1:0] r_g1, n_g1;
    logic [WordW-1:0] r_g2, n_g2;
    logic [WordW-1:0] r_last, n_last;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [AddrW-1:0] r_slot, n_slot;
    logic [WordW-1:0] r_out, n_out;
    logic             r_ov, n_ov;

    t_mm_req          mm_req;
    logic [WordW-1:0] mm_res;
    logic             mm_done;
    t_tbl_req         tbl_req;
    logic [WordW-1:0] tbl_data;

    logic             in_acc;
    logic             out_free;
    logic [WordW-1:0] seed_eff;
    logic [WordW-1:0] draw_val;

    clsr_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_res   (mm_res),
        .o_done  (mm_done)
    );

    clsr_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_data)
    );

    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign seed_eff = (i_seed_value == '0) ? WordW'(1) : i_seed_value;

    always_comb begin
        if (tbl_data > mm_res) begin
            draw_val = tbl_data - mm_res;
        end else begin
            draw_val = WrapAdd - (mm_res - tbl_data);
        end
    end

    always_comb begin
        n_state = r_state;
        n_g1    = r_g1;
        n_g2    = r_g2;
        n_last  = r_last;
        n_cnt   = r_cnt;
        n_slot  = r_slot;
        n_out   = r_out;
        n_ov    = r_ov && i_stall;
        mm_req  = '{start: 1'b0, sel: GEN_ONE, operand: r_g1};
        tbl_req = '{rd_en: 1'b0, rd_addr: slot_of(r_last), wr_en: 1'b0,
                    wr_addr: r_slot, wr_data: r_g1};

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_reseed) begin
                        n_g1    = seed_eff;
                        n_g2    = seed_eff;
                        n_cnt   = '0;
                        n_state = ST_SEED_ISSUE;
                    end else begin
                        n_state = ST_DRAW_G1;
                    end
                end
            end
            ST_SEED_ISSUE: begin
                mm_req.start = 1'b1;
                n_state      = ST_SEED_WAIT;
            end
            ST_SEED_WAIT: begin
                if (mm_done) begin
                    n_g1 = mm_res;
                    // past warm-up, fill the table from the top entry down
                    if (r_cnt >= WarmSteps) begin
                        tbl_req.wr_en   = 1'b1;
                        tbl_req.wr_addr = AddrW'(LastStep - r_cnt);
                        tbl_req.wr_data = mm_res;
                    end
                    if (r_cnt == LastStep) begin
                        n_last  = mm_res;
                        n_cnt   = '0;
                        n_state = ST_DRAW_G1;
                    end else begin
                        n_cnt   = r_cnt + CntW'(1);
                        n_state = ST_SEED_ISSUE;
                    end
                end
            end
            ST_DRAW_G1: begin
                mm_req.start  = 1'b1;
                tbl_req.rd_en = 1'b1;
                n_slot        = slot_of(r_last);
                n_state       = ST_DRAW_G2;
            end
            ST_DRAW_G2: begin
                mm_req.start   = 1'b1;
                mm_req.sel     = GEN_TWO;
                mm_req.operand = r_g2;
                n_state        = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
                n_g1    = mm_res;
                n_state = ST_DRAW_FINISH;
            end
            ST_DRAW_FINISH: begin
                // hold here until the output register can take the word
                if (out_free) begin
                    tbl_req.wr_en = 1'b1;
                    n_g2          = mm_res;
                    n_last        = draw_val;
                    n_out         = draw_val;
                    n_ov          = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_g1    <= GenOneRst;
            r_g2    <= GenTwoRst;
            r_last  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_g1    <= n_g1;
            r_g2    <= n_g2;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    assign o_valid        = r_ov;
    assign o_random_value = r_out;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_random_value != '0) && (o_random_value <= WrapAdd))
        else $error("output word outside 1..2147483562");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SEED_ISSUE && r_state != ST_SEED_WAIT) |-> (r_cnt == '0))
        else $error("step counter nonzero outside reseed");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == ST_SEED_WAIT || r_state == ST_DRAW_WAIT ||
                     r_state == ST_DRAW_FINISH))
        else $error("multiplier result arrived with no step waiting");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_SEED_ISSUE || r_state == ST_DRAW_G1))
        else $error("accepted request did not start a draw");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("held output word dropped");

endmodule

/* src/clsr_modmul.sv */
// ============================================================================
// clsr_modmul: shared constant modular multiplier
// Two-stage unit: multiply by the selected generator constant, then fold the
// high part by 2^31 mod m and reduce with one compare and subtract.
// ============================================================================
module clsr_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  clsr_pkg::t_mm_req         i_req,
    output logic [clsr_pkg::WordW-1:0] o_res,
    output logic                      o_done
);
    import clsr_pkg::*;

    logic [ProdW-1:0] r_prod;
    t_gen             r_sel;
    logic             r_v1;
    logic [WordW-1:0] r_res;
    logic             r_v2;

    logic [WordW-1:0] mul_k;
    logic [ProdW-1:0] n_prod;
    logic [MulW-1:0]  prod_hi;
    logic [7:0]       fold_k;
    logic [WordW-1:0] mod_m;
    logic [WordW:0]   fold_sum;
    logic [WordW-1:0] n_res;

    always_comb begin
        mul_k  = (i_req.sel == GEN_ONE) ? MulOne : MulTwo;
        n_prod = ProdW'(i_req.operand) * ProdW'(mul_k[MulW-1:0]);
    end

    always_comb begin
        prod_hi  = r_prod[ProdW-1:WordW];
        fold_k   = (r_sel == GEN_ONE) ? FoldOne : FoldTwo;
        mod_m    = (r_sel == GEN_ONE) ? ModOne : ModTwo;
        fold_sum = {1'b0, r_prod[WordW-1:0]} +
                   ((WordW+1)'(prod_hi) * (WordW+1)'(fold_k));
        if (fold_sum >= {1'b0, mod_m}) begin
            n_res = WordW'(fold_sum - {1'b0, mod_m});
        end else begin
            n_res = fold_sum[WordW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
        end
    end

    // hold the last result until the next operation reaches the output
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= n_prod;
            r_sel  <= i_req.sel;
        end
        if (r_v1) begin
            r_res <= n_res;
        end
    end

    assign o_res  = r_res;
    assign o_done = r_v2;

endmodule

/* src/clsr_table.sv */
// ============================================================================
// clsr_table: shuffle table storage
// 32-entry memory with registered read; per-entry valid bits make entries
// read as zero until first written after reset.
// ============================================================================
module clsr_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  clsr_pkg::t_tbl_req        i_req,
    output logic [clsr_pkg::WordW-1:0] o_rd_data
);
    import clsr_pkg::*;

    logic [WordW-1:0]      r_mem [TableDepth];
    logic [TableDepth-1:0] r_valid;
    logic [WordW-1:0]      r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* verif/combined_lcg_shuffle_rng_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// combined_lcg_shuffle_rng_test: self-checking bench for the shuffled LCG pair
// Feeds draw requests, some with reseeds, through the valid/stall input port.
// It predicts every output word with a local model of both generators and
// the shuffle table, and checks the results in order. Both sides idle at
// random; one long receiver hold-off and two drain pauses add pressure.
// ============================================================================
module combined_lcg_shuffle_rng_test;

    import clsr_pkg::*;

    typedef logic [WordW-1:0] t_word;

    typedef struct {
        bit    reseed;
        t_word seed;
        bit    drain_first;
    } t_draw_req;

    localparam longint unsigned MUL_A      = 40014;
    localparam longint unsigned MOD_A      = 2147483563;
    localparam longint unsigned MUL_B      = 40692;
    localparam longint unsigned MOD_B      = 2147483399;
    localparam int unsigned     SLOT_SPAN  = 67108862;
    localparam int unsigned     WRAP_TOP   = 2147483562;
    localparam int unsigned     SEED_TOP   = 2147483562;
    localparam int unsigned     SLOTS      = 32;
    localparam int unsigned     WARM_STEPS = 8;
    localparam int unsigned     RAND_DRAWS = 500;
    localparam int unsigned     HOLD_LEN   = 400;
    localparam int unsigned     CYCLE_CAP  = 400000;

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_valid      = 1'b0;
    logic  i_reseed     = 1'b0;
    t_word i_seed_value = '0;
    logic  i_stall      = 1'b0;
    logic  o_stall;
    logic  o_valid;
    t_word o_random_value;

    combined_lcg_shuffle_rng dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_reseed       (i_reseed),
        .i_seed_value   (i_seed_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_random_value (o_random_value)
    );

    initial forever #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Local model of the generator state
    // ------------------------------------------------------------------
    t_word lcg_a;
    t_word lcg_b;
    t_word shuffle_mem [SLOTS];
    t_word prev_draw;

    function automatic t_word advance_a(t_word x);
        return t_word'((longint'(x) * MUL_A) % MOD_A);
    endfunction

    function automatic t_word advance_b(t_word y);
        return t_word'((longint'(y) * MUL_B) % MOD_B);
    endfunction

    function automatic t_word predict_draw(bit reseed, t_word seed);
        t_word       x;
        int unsigned idx;
        int unsigned entry;
        int unsigned val;
        if (reseed) begin
            x = (seed == '0) ? t_word'(1) : seed;
            lcg_b = x;
            for (int i = 0; i < WARM_STEPS; i++) x = advance_a(x);
            for (int i = SLOTS - 1; i >= 0; i--) begin
                x = advance_a(x);
                shuffle_mem[i] = x;
            end
            lcg_a     = x;
            prev_draw = shuffle_mem[0];
        end
        lcg_a = advance_a(lcg_a);
        lcg_b = advance_b(lcg_b);
        idx = prev_draw / SLOT_SPAN;
        if (idx >= SLOTS) idx = SLOTS - 1;
        entry = shuffle_mem[idx];
        if (entry > lcg_b) begin
            val = entry - lcg_b;
        end else begin
            val = WRAP_TOP - (lcg_b - entry);
        end
        shuffle_mem[idx] = lcg_a;
        prev_draw        = t_word'(val);
        return prev_draw;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    t_draw_req   pending_reqs [$];
    t_word       draws_due [$];
    int unsigned n_sent     = 0;
    int unsigned n_got      = 0;
    int unsigned n_errors   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    bit          took;
    t_draw_req   next_req;
    t_word       want;

    task automatic note_mismatch(string what, t_word got, t_word exp_val);
        $display("mismatch at cycle %0d: %s, got %0d, want %0d",
                 cycle_cnt, what, got, exp_val);
        n_errors++;
    endtask

    // no idling while the counts sit in the quiet window
    function automatic bit take_gap(int unsigned count);
        if (count >= 200 && count < 300) return 1'b0;
        return $urandom_range(0, 99) < 18;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                draws_due.push_back(predict_draw(i_reseed, i_seed_value));
                n_sent++;
            end
            // hold a stalled word; otherwise offer the next one
            if (took || !i_valid) begin
                if (pending_reqs.size() != 0 && !take_gap(n_sent) &&
                    (!pending_reqs[0].drain_first || draws_due.size() == 0)) begin
                    next_req = pending_reqs.pop_front();
                    i_valid      <= 1'b1;
                    i_reseed     <= next_req.reseed;
                    i_seed_value <= next_req.seed;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_got++;
                if (draws_due.size() == 0) begin
                    note_mismatch("random_value with nothing due", o_random_value, '0);
                end else begin
                    want = draws_due.pop_front();
                    if (o_random_value !== want)
                        note_mismatch("random_value", o_random_value, want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && n_got >= 100) begin
            // long hold-off: let the block back up into its input
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= take_gap(n_got);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("[combined_lcg_shuffle_rng] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_draw(bit reseed, t_word seed, bit drain_first = 1'b0);
        t_draw_req r;
        r.reseed      = reseed;
        r.seed        = seed;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endtask

    function automatic t_word pick_seed();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return t_word'($urandom_range(0, SEED_TOP));
        if (roll < 85) return t_word'($urandom_range(0, 1000));
        return t_word'($urandom_range(2147483300, 2147483647));
    endfunction

    initial begin
        lcg_a     = t_word'(1);
        lcg_b     = t_word'(123456789);
        prev_draw = '0;
        foreach (shuffle_mem[i]) shuffle_mem[i] = '0;

        // draws straight from the reset state, table still all zeros
        queue_draw(1'b0, '0);
        queue_draw(1'b0, '1);
        queue_draw(1'b0, '0);
        // zero seed acts as one
        queue_draw(1'b1, '0);
        queue_draw(1'b0, '0);
        queue_draw(1'b1, t_word'(1));
        queue_draw(1'b1, t_word'(SEED_TOP));
        queue_draw(1'b0, '0);
        queue_draw(1'b0, t_word'(SEED_TOP));
        // seed equal to the second modulus zeroes generator two
        queue_draw(1'b1, t_word'(MOD_B));
        queue_draw(1'b0, '0);
        queue_draw(1'b0, '0);
        queue_draw(1'b0, '0);
        // seed equal to the first modulus zeroes generator one
        queue_draw(1'b1, t_word'(MOD_A));
        queue_draw(1'b0, '0);
        queue_draw(1'b0, '0);
        // seeds above a modulus act as seed mod m
        queue_draw(1'b1, '1);
        queue_draw(1'b0, '0);
        queue_draw(1'b1, 31'd715827882);
        queue_draw(1'b0, 31'd1431655765);
        queue_draw(1'b1, 31'd1431655765);
        queue_draw(1'b0, '1);

        for (int n = 0; n < RAND_DRAWS; n++) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_draw(1'b1, pick_seed(), n == 0 || n == 250);
            end else begin
                // seed is ignored on a plain draw; keep it noisy
                queue_draw(1'b0, t_word'($urandom), n == 0 || n == 250);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_valid) @(posedge i_clk);
        while (draws_due.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("[combined_lcg_shuffle_rng] OK");
        end else begin
            $display("[combined_lcg_shuffle_rng] ERROR");
        end
        $finish;
    end

endmodule
